[rtl/cfp_pkg.sv]
// Shared types, constants and helpers for the command frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package cfp_pkg;

  localparam int MaxPayload = 1024;
  localparam int NumClasses = 7;
  localparam int CountW = $clog2(MaxPayload + 1);

  localparam logic [2:0] CLS_IDENTIFY  = 3'd0;
  localparam logic [2:0] CLS_ERASE     = 3'd1;
  localparam logic [2:0] CLS_ERASE_ALL = 3'd2;
  localparam logic [2:0] CLS_WRITE     = 3'd3;
  localparam logic [2:0] CLS_READ      = 3'd4;
  localparam logic [2:0] CLS_RESET     = 3'd5;
  localparam logic [2:0] CLS_START     = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [2:0] REG_START_BYTE = 3'd0;

  localparam logic [15:0] ERASE_LEN_SHORT = 16'd4;
  localparam logic [15:0] ERASE_LEN_LONG  = 16'd8;
  localparam logic [15:0] RW_LEN          = 16'd6;

  typedef struct packed {
    logic [7:0]                 start_byte;
    logic [NumClasses-1:0][7:0] codes;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [2:0]  command_class;
    logic [15:0] frame_length;
    logic [1:0]  frame_status;
  } result_t;

  function automatic logic length_fits(input logic [2:0] cls, input logic [15:0] len);
    logic fits;
    unique case (cls)
      CLS_ERASE: fits = (len == ERASE_LEN_SHORT) || (len == ERASE_LEN_LONG);
      CLS_WRITE: fits = (len >= RW_LEN);
      CLS_READ:  fits = (len == RW_LEN);
      default:   fits = (len == 16'd0);
    endcase
    return fits;
  endfunction

endpackage
`default_nettype wire

[rtl/cfp_regs.sv]
// Configuration register file: start byte and the seven command codes.
// Depends on cfp_pkg.
`default_nettype none
module cfp_regs
  import cfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_START_BYTE) begin
        cfg.start_byte <= cfg_data;
      end else begin
        cfg.codes[cfg_index - 3'd1] <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cfp_fsm.sv]
// Frame state machine: hunt, command match, length, payload, checksum.
// Depends on cfp_pkg; fed by cfp_regs, drains into cfp_skid.
`default_nettype none
module cfp_fsm
  import cfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_beat,
  input  wire logic [7:0] rx_byte,
  output logic            has_result,
  output result_t         result
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_CODE   = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [2:0]        held_class, held_class_next;
  logic [15:0]       declared_length, declared_length_next;
  logic [CountW-1:0] received_count, received_count_next;
  logic              code_hit;
  logic [2:0]        code_class;
  logic [15:0]       count_inc;

  always_comb begin
    code_hit   = 1'b0;
    code_class = CLS_IDENTIFY;
    for (int i = NumClasses - 1; i >= 0; i--) begin
      if (cfg.codes[i] == rx_byte) begin
        code_hit   = 1'b1;
        code_class = 3'(i);
      end
    end
  end

  assign count_inc = 16'(received_count) + 16'd1;

  always_comb begin
    phase_next           = phase;
    running_xor_next     = running_xor;
    held_class_next      = held_class;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    has_result           = 1'b0;
    result               = '0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == cfg.start_byte) begin
          running_xor_next = rx_byte;
          phase_next       = PH_CODE;
        end
      end
      PH_CODE: begin
        if (code_hit) begin
          held_class_next  = code_class;
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = PH_LEN_LO;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        declared_length_next = {8'd0, rx_byte};
        running_xor_next     = running_xor ^ rx_byte;
        phase_next           = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        declared_length_next = {rx_byte, declared_length[7:0]};
        running_xor_next     = running_xor ^ rx_byte;
        received_count_next  = '0;
        if (declared_length_next > 16'(MaxPayload)) begin
          phase_next           = PH_HUNT;
          has_result           = 1'b1;
          result.kind          = 1'b1;
          result.command_class = held_class;
          result.frame_length  = declared_length_next;
          result.frame_status  = ST_OVERFLOW;
        end else if (declared_length_next != 16'd0) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_CHECK;
        end
      end
      PH_DATA: begin
        running_xor_next     = running_xor ^ rx_byte;
        received_count_next  = CountW'(count_inc);
        if (count_inc == declared_length) begin
          phase_next = PH_CHECK;
        end
        has_result           = 1'b1;
        result.kind          = 1'b0;
        result.data_byte     = rx_byte;
        result.byte_index    = received_count[9:0];
        result.command_class = held_class;
        result.frame_length  = declared_length;
        result.frame_status  = ST_OK;
      end
      PH_CHECK: begin
        phase_next           = PH_HUNT;
        has_result           = 1'b1;
        result.kind          = 1'b1;
        result.command_class = held_class;
        result.frame_length  = declared_length;
        if (running_xor != rx_byte) begin
          result.frame_status = ST_BAD_SUM;
        end else if (!length_fits(held_class, declared_length)) begin
          result.frame_status = ST_BAD_LEN;
        end else begin
          result.frame_status = ST_OK;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      running_xor     <= '0;
      held_class      <= '0;
      declared_length <= '0;
      received_count  <= '0;
    end else if (in_beat) begin
      phase           <= phase_next;
      running_xor     <= running_xor_next;
      held_class      <= held_class_next;
      declared_length <= declared_length_next;
      received_count  <= received_count_next;
    end
  end

endmodule
`default_nettype wire

[rtl/cfp_skid.sv]
// Output register with one skid entry; decouples input and output stalls.
// Depends on cfp_pkg.
`default_nettype none
module cfp_skid
  import cfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/command_frame_parser.sv]
// Command frame parser top level: config registers, frame FSM, output skid.
// Depends on cfp_pkg, cfp_regs, cfp_fsm and cfp_skid.
//
// Takes one received byte per beat and hunts for the start byte, then a
// command byte matching one of seven codes, a little-endian 16-bit length,
// the payload and an XOR checksum byte. Each payload byte leaves as a beat
// with m_tuser low; the checksum byte, or a length above 1024, leaves a
// frame-end report with m_tuser high and a status. Every byte is handled in
// the cycle it is accepted and its result is registered, in the skid entry
// while the output stalls, so one byte per cycle is sustained; the only
// limit is the output side, whose register and single skid entry hold two
// results before s_tready drops. Write configuration only when idle.
`default_nettype none
module command_frame_parser
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // data_byte, byte_index, command_class, frame_length, frame_status, zero pad
  output logic [39:0]      m_tdata,
  output logic             m_tuser    // out_kind
);

  cfg_t    cfg;
  logic    in_beat;
  logic    has_result;
  result_t result;
  result_t out_data;

  assign in_beat = s_tvalid && s_tready;

  cfp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfp_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_beat    (in_beat),
    .rx_byte    (s_tdata),
    .has_result (has_result),
    .result     (result)
  );

  cfp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_beat && has_result),
    .push_data (result),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tuser = out_data.kind;
  assign m_tdata = {1'b0, out_data.frame_status, out_data.frame_length,
                    out_data.command_class, out_data.byte_index, out_data.data_byte};

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[38:37] == ST_OK))
    else $error("payload beat with non-ok status");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[17:0] == 18'd0))
    else $error("report beat carries data or index");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with output empty");

endmodule
`default_nettype wire

[test/tb_command_frame_parser.sv]
// Self-checking testbench for command_frame_parser: random and directed byte
// streams with random idling on both sides, checked against a local parser model.
// Depends on cfp_pkg and the command_frame_parser RTL.
`timescale 1ns / 1ps
module tb_command_frame_parser;
  import cfp_pkg::*;

  localparam logic [2:0] REG_FIRST_CODE = 3'd1;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  typedef enum logic [2:0] {
    HUNT, CMD, LEN_LO, LEN_HI, PAYLOAD, CHECKSUM
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;      // rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // data_byte, byte_index, command_class, frame_length, frame_status, zero pad
  logic [39:0] m_tdata;
  logic        m_tuser;          // out_kind

  command_frame_parser DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0]   rx_bytes_q[$];
  result_t      frame_outputs_q[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off_req = 0;
  int           hold_off_served = 0;
  int           hold_off_left = 0;
  int           stuck_cycles = 0;
  bit           in_fire = 1'b0;

  // configuration as written to the block
  logic [7:0]   cfg_start = '0;
  logic [7:0]   cfg_codes [NumClasses];

  // parser model state
  parse_phase_e mdl_phase = HUNT;
  logic [7:0]   mdl_xor = '0;
  logic [2:0]   mdl_class = '0;
  logic [15:0]  mdl_len = '0;
  logic [15:0]  mdl_count = '0;

  initial for (int i = 0; i < NumClasses; i++) cfg_codes[i] = '0;

  function automatic bit len_suits(input logic [2:0] cls, input logic [15:0] len);
    case (cls)
      CLS_ERASE: return len == ERASE_LEN_SHORT || len == ERASE_LEN_LONG;
      CLS_WRITE: return len >= RW_LEN;
      CLS_READ:  return len == RW_LEN;
      default:   return len == 16'd0;
    endcase
  endfunction

  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    case (mdl_phase)
      HUNT: begin
        if (b == cfg_start) begin
          mdl_xor = b;
          mdl_phase = CMD;
        end
      end
      CMD: begin
        mdl_phase = HUNT;
        // scan downwards so the lowest matching class wins
        for (int i = NumClasses - 1; i >= 0; i--) begin
          if (cfg_codes[i] == b) begin
            mdl_class = 3'(i);
            mdl_phase = LEN_LO;
          end
        end
        if (mdl_phase == LEN_LO) mdl_xor ^= b;
      end
      LEN_LO: begin
        mdl_len = {8'h00, b};
        mdl_xor ^= b;
        mdl_phase = LEN_HI;
      end
      LEN_HI: begin
        mdl_len[15:8] = b;
        mdl_xor ^= b;
        mdl_count = '0;
        if (mdl_len > 16'(MaxPayload)) begin
          mdl_phase = HUNT;
          hit = 1'b1;
          res.kind = 1'b1;
          res.frame_status = ST_OVERFLOW;
        end else begin
          mdl_phase = (mdl_len != 16'd0) ? PAYLOAD : CHECKSUM;
        end
      end
      PAYLOAD: begin
        hit = 1'b1;
        res.kind = 1'b0;
        res.data_byte = b;
        res.byte_index = mdl_count[9:0];
        res.frame_status = ST_OK;
        mdl_xor ^= b;
        mdl_count = mdl_count + 16'd1;
        if (mdl_count == mdl_len) mdl_phase = CHECKSUM;
      end
      CHECKSUM: begin
        hit = 1'b1;
        res.kind = 1'b1;
        if (mdl_xor != b) res.frame_status = ST_BAD_SUM;
        else if (!len_suits(mdl_class, mdl_len)) res.frame_status = ST_BAD_LEN;
        else res.frame_status = ST_OK;
        mdl_phase = HUNT;
      end
      default: mdl_phase = HUNT;
    endcase
    res.command_class = mdl_class;
    res.frame_length = mdl_len;
    return hit;
  endfunction

  task automatic note_mismatch(input string what, input logic [39:0] got,
                               input logic [39:0] want);
    if (fail_count < 40)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // driver: offer the next byte once the current beat has gone
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_fire)) begin
      if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= rx_bytes_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      m_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_served != hold_off_req) begin
      m_tready <= 1'b0;
      hold_off_served <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    bit      in_beat;
    bit      out_beat;
    in_beat = !rst && s_tvalid === 1'b1 && s_tready === 1'b1;
    out_beat = !rst && m_tvalid === 1'b1 && m_tready === 1'b1;
    in_fire <= in_beat;
    if (out_beat) begin
      got.kind = m_tuser;
      got.data_byte = m_tdata[7:0];
      got.byte_index = m_tdata[17:8];
      got.command_class = m_tdata[20:18];
      got.frame_length = m_tdata[36:21];
      got.frame_status = m_tdata[38:37];
      if (frame_outputs_q.size() == 0) begin
        note_mismatch("unexpected beat", m_tdata, '0);
      end else begin
        want = frame_outputs_q.pop_front();
        if (got.kind != want.kind)
          note_mismatch("out_kind", 40'(got.kind), 40'(want.kind));
        if (got.data_byte != want.data_byte)
          note_mismatch("data_byte", 40'(got.data_byte), 40'(want.data_byte));
        if (got.byte_index != want.byte_index)
          note_mismatch("byte_index", 40'(got.byte_index), 40'(want.byte_index));
        if (got.command_class != want.command_class)
          note_mismatch("command_class", 40'(got.command_class),
                        40'(want.command_class));
        if (got.frame_length != want.frame_length)
          note_mismatch("frame_length", 40'(got.frame_length), 40'(want.frame_length));
        if (got.frame_status != want.frame_status)
          note_mismatch("frame_status", 40'(got.frame_status), 40'(want.frame_status));
      end
    end
    if (in_beat) begin
      if (parse_rx_byte(s_tdata, want)) frame_outputs_q.push_back(want);
    end
    if (in_beat || out_beat) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles > STUCK_LIMIT) begin
      $display("tb_command_frame_parser NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_START_BYTE) cfg_start = val;
    else cfg_codes[idx - REG_FIRST_CODE] = val;
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_START_BYTE, c.start_byte);
    for (int i = 0; i < NumClasses; i++) write_reg(REG_FIRST_CODE + 3'(i), c.codes[i]);
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (4) @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (rx_bytes_q.size() != 0 || s_tvalid || frame_outputs_q.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic bit is_known_code(input logic [7:0] b);
    for (int i = 0; i < NumClasses; i++) if (cfg_codes[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] unknown_code();
    logic [7:0] b;
    do b = 8'($urandom);
    while (is_known_code(b));
    return b;
  endfunction

  task automatic queue_frame(input logic [2:0] cls, input logic [15:0] len,
                             input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cfg_start ^ cfg_codes[cls] ^ len[7:0] ^ len[15:8];
    rx_bytes_q.push_back(cfg_start);
    rx_bytes_q.push_back(cfg_codes[cls]);
    rx_bytes_q.push_back(len[7:0]);
    rx_bytes_q.push_back(len[15:8]);
    if (len <= 16'(MaxPayload)) begin
      for (int k = 0; k < int'(len); k++) begin
        b = 8'($urandom);
        sum ^= b;
        rx_bytes_q.push_back(b);
      end
      rx_bytes_q.push_back(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
    end
  endtask

  task automatic queue_random_traffic();
    int          pick;
    int          cut;
    logic [2:0]  cls;
    logic [15:0] len;
    pick = $urandom_range(99);
    cls = 3'($urandom_range(NumClasses - 1));
    if (pick < 74) begin
      case (cls)
        CLS_ERASE: len = $urandom_range(1) ? ERASE_LEN_SHORT : ERASE_LEN_LONG;
        CLS_WRITE: len = 16'($urandom_range(6, 14));
        CLS_READ:  len = RW_LEN;
        default:   len = 16'd0;
      endcase
      if ($urandom_range(4) == 0) len = 16'($urandom_range(12));
      queue_frame(cls, len, $urandom_range(6) == 0);
    end else if (pick < 81) begin
      case ($urandom_range(3))
        0:       len = 16'(MaxPayload + 1);
        1:       len = 16'hFFFF;
        default: len = 16'($urandom_range(65535, MaxPayload + 1));
      endcase
      queue_frame(cls, len, 1'b0);
    end else if (pick < 89) begin
      rx_bytes_q.push_back(cfg_start);
      rx_bytes_q.push_back(unknown_code());
    end else if (pick < 94) begin
      // truncated frame: header cut short, later bytes fall into it
      cut = $urandom_range(3, 1);
      rx_bytes_q.push_back(cfg_start);
      if (cut > 1) rx_bytes_q.push_back(cfg_codes[cls]);
      if (cut > 2) rx_bytes_q.push_back(8'($urandom_range(5)));
    end else begin
      repeat ($urandom_range(3, 1)) rx_bytes_q.push_back(8'($urandom));
    end
  endtask

  task automatic run_phase(input cfg_t c, input int send_pct, input int recv_pct,
                           input int budget, input bit hold_off, input bit long_frame);
    int base;
    apply_config(c);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    base = rx_bytes_q.size();
    if (long_frame) queue_frame(CLS_WRITE, 16'(MaxPayload), 1'b0);
    while (rx_bytes_q.size() - base < budget) queue_random_traffic();
    if (hold_off) hold_off_req++;
    wait_drained();
  endtask

  initial begin
    cfg_t cfg_plain;
    cfg_t cfg_zero;
    cfg_t cfg_edge;
    cfg_t cfg_rand;

    cfg_plain.start_byte = 8'hA5;
    for (int i = 0; i < NumClasses; i++) cfg_plain.codes[i] = 8'h10 + 8'(i);
    cfg_zero = '0;
    cfg_edge.start_byte = 8'hFF;
    cfg_edge.codes[CLS_IDENTIFY] = 8'hFF;
    cfg_edge.codes[CLS_ERASE] = 8'h00;
    cfg_edge.codes[CLS_ERASE_ALL] = 8'h80;
    cfg_edge.codes[CLS_WRITE] = 8'h7F;
    cfg_edge.codes[CLS_READ] = 8'h80;
    cfg_edge.codes[CLS_RESET] = 8'h01;
    cfg_edge.codes[CLS_START] = 8'hFE;
    cfg_rand.start_byte = 8'($urandom);
    for (int i = 0; i < NumClasses; i++) cfg_rand.codes[i] = 8'($urandom);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: noise, unknown command, good frame, bad checksum,
    // bad length with good checksum, length overflow
    apply_config(cfg_plain);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(cfg_start);
    rx_bytes_q.push_back(unknown_code());
    queue_frame(CLS_IDENTIFY, 16'd0, 1'b0);
    queue_frame(CLS_ERASE, ERASE_LEN_SHORT, 1'b1);
    queue_frame(CLS_READ, 16'd0, 1'b0);
    queue_frame(CLS_START, 16'hFFFF, 1'b0);
    wait_drained();

    run_phase(cfg_plain, 0, 0, 40, 1'b0, 1'b0);
    run_phase(cfg_zero, 69, 0, 30, 1'b0, 1'b0);
    run_phase(cfg_edge, 0, 69, 40, 1'b1, 1'b0);
    run_phase(cfg_rand, 27, 27, 0, 1'b0, 1'b1);
    run_phase(cfg_plain, 27, 27, 24, 1'b1, 1'b0);

    recv_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && frame_outputs_q.size() == 0) begin
      $display("tb_command_frame_parser OK");
    end else begin
      $display("tb_command_frame_parser NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cfp_pkg.sv
rtl/cfp_regs.sv
rtl/cfp_fsm.sv
rtl/cfp_skid.sv
rtl/command_frame_parser.sv
test/tb_command_frame_parser.sv
